FILE: hdl/mns_pkg.sv
package mns_pkg;

  // Note table geometry.
  localparam int MAX_NOTES = 128;
  localparam int NOTE_AW   = $clog2(MAX_NOTES);

  // Field widths.
  localparam int CMD_W     = 2;
  localparam int SESS_W    = 32;
  localparam int PITCH_W   = 13;
  localparam int CODE_W    = 8;
  localparam int ENTRY_W   = PITCH_W + CODE_W;
  localparam int LEN_W     = 16;
  localparam int KIND_W    = 2;
  localparam int TEMPO_W   = 10;
  localparam int SONG_W    = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPO = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SONG  = 1'b1;
  localparam logic [TEMPO_W-1:0]   TEMPO_RESET = 10'd120;
  localparam logic [SONG_W-1:0]    SONG_RESET  = 8'd1;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  // Event kinds.
  localparam logic [KIND_W-1:0] EVT_NOTE = 2'd0;
  localparam logic [KIND_W-1:0] EVT_STOP = 2'd1;
  localparam logic [KIND_W-1:0] EVT_DONE = 2'd2;

  // Serial divider sizing: a whole note is 240000 ms at one beat per minute.
  localparam int WHOLE_NOTE_MS = 240000;
  localparam int DVD_W         = 18;
  localparam int DVS_W         = 10;
  localparam int LEN_MAX       = 65535;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: hdl/mns_channels.sv
interface mns_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [mns_pkg::CMD_W-1:0]        cmd;
  logic [mns_pkg::SESS_W-1:0]       session_ms;
  logic [mns_pkg::NOTE_AW-1:0]      start_note;
  logic [mns_pkg::NOTE_AW-1:0]      entry_index;
  logic [mns_pkg::PITCH_W-1:0]      entry_pitch;
  logic signed [mns_pkg::CODE_W-1:0] entry_code;

  modport source (
    output valid, cmd, session_ms, start_note, entry_index, entry_pitch, entry_code,
    input  ready
  );
  modport sink (
    input  valid, cmd, session_ms, start_note, entry_index, entry_pitch, entry_code,
    output ready
  );
endinterface

interface mns_evt_if;
  logic                         valid;
  logic                         ready;
  logic [mns_pkg::KIND_W-1:0]   event_kind;
  logic [mns_pkg::PITCH_W-1:0]  pitch_hz;
  logic [mns_pkg::LEN_W-1:0]    length_ms;
  logic [mns_pkg::NOTE_AW-1:0]  next_note;

  modport source (
    output valid, event_kind, pitch_hz, length_ms, next_note,
    input  ready
  );
  modport sink (
    input  valid, event_kind, pitch_hz, length_ms, next_note,
    output ready
  );
endinterface

FILE: hdl/mns_ram.sv
module mns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/mns_div.sv
// Restoring divider, one quotient bit per cycle.
module mns_div (
  input  logic              clk,
  input  logic              rst,
  input  mns_pkg::div_req_t req,
  output mns_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(mns_pkg::DVD_W + 1);

  logic [mns_pkg::DVD_W-1:0] quo;
  logic [mns_pkg::DVS_W-1:0] rem;
  logic [mns_pkg::DVS_W-1:0] dvs;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic                      done;

  logic [mns_pkg::DVS_W:0]   trial;
  logic                      fits;

  assign trial = {rem, quo[mns_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
        cnt  <= CNT_W'(mns_pkg::DVD_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= mns_pkg::DVS_W'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[mns_pkg::DVS_W-1:0];
        end
        quo <= {quo[mns_pkg::DVD_W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: hdl/melody_note_sequencer.sv
// Channel   Dir   Request contents
// cmd_ch    in    cmd, session_ms, start_note, entry_index, entry_pitch, entry_code
// evt_ch    out   event_kind, pitch_hz, length_ms, next_note
// cfg_*     in    write enable, register index, write data (no handshake)
//
// A table write, a tick that ends no note and an ignored command finish in S_READY.
// A tick that finishes the song or stops the session goes on through S_EMIT.
// A request that starts a note takes a table read, then two passes of the shared
// 18-step serial divider; a zero code skips the second pass.
// Reset is synchronous and clears control state; the note table is not cleared.
// A finished event waits in the output register while the next request is taken.
module melody_note_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  mns_cmd_if.sink                        cmd_ch,
  mns_evt_if.source                      evt_ch,
  input  logic                           cfg_wr_en,
  input  logic [mns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mns_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_READY,
    S_FETCH,
    S_LOAD,
    S_WHOLE,
    S_DIVIDE,
    S_EMIT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [mns_pkg::TEMPO_W-1:0] tempo_bpm;
  logic [mns_pkg::SONG_W-1:0]  song_notes;

  // Playback state.
  logic [mns_pkg::NOTE_AW-1:0] note_pointer;
  logic [mns_pkg::LEN_W-1:0]   note_remaining;
  logic [mns_pkg::SESS_W-1:0]  session_remaining;
  logic                        playing;

  // Note being started.
  logic [mns_pkg::PITCH_W-1:0] note_pitch;
  logic [mns_pkg::CODE_W-1:0]  note_code;

  // Pending event and the output register.
  logic [mns_pkg::KIND_W-1:0]  res_kind;
  logic [mns_pkg::PITCH_W-1:0] res_pitch;
  logic [mns_pkg::LEN_W-1:0]   res_len;
  logic [mns_pkg::NOTE_AW-1:0] res_next;
  logic                        out_valid;
  logic [mns_pkg::KIND_W-1:0]  out_kind;
  logic [mns_pkg::PITCH_W-1:0] out_pitch;
  logic [mns_pkg::LEN_W-1:0]   out_len;
  logic [mns_pkg::NOTE_AW-1:0] out_next;

  mns_pkg::div_req_t div_req;
  mns_pkg::div_rsp_t div_rsp;

  logic                        accept;
  logic                        ram_wr_en;
  logic                        ram_rd_en;
  logic [mns_pkg::ENTRY_W-1:0] ram_rd_data;

  logic [mns_pkg::SONG_W-1:0]  song_len;
  logic [mns_pkg::NOTE_AW-1:0] start_idx;
  logic                        is_last;
  logic [mns_pkg::SESS_W-1:0]  session_dec;
  logic [mns_pkg::LEN_W-1:0]   note_dec;
  logic [mns_pkg::TEMPO_W-1:0] tempo_eff;
  logic [mns_pkg::CODE_W-1:0]  code_mag;
  logic [mns_pkg::DVD_W:0]     len_sum;
  logic [mns_pkg::LEN_W-1:0]   len_sat;
  logic                        out_free;

  assign accept    = cmd_ch.valid && cmd_ch.ready;
  assign ram_wr_en = accept && (cmd_ch.cmd == mns_pkg::CMD_WRITE);
  assign ram_rd_en = (state == S_FETCH);
  assign out_free  = !out_valid || evt_ch.ready;

  mns_ram #(
    .WIDTH(mns_pkg::ENTRY_W),
    .DEPTH(mns_pkg::MAX_NOTES)
  ) u_note_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(cmd_ch.entry_index),
    .wr_data({cmd_ch.entry_pitch, cmd_ch.entry_code}),
    .rd_en  (ram_rd_en),
    .rd_addr(note_pointer),
    .rd_data(ram_rd_data)
  );

  mns_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // Song length is clamped to one through the table depth.
  always_comb begin
    if (song_notes == '0) begin
      song_len = mns_pkg::SONG_W'(1);
    end else if (song_notes > mns_pkg::SONG_W'(mns_pkg::MAX_NOTES)) begin
      song_len = mns_pkg::SONG_W'(mns_pkg::MAX_NOTES);
    end else begin
      song_len = song_notes;
    end
  end

  // A start index at or past the end of the song begins at the first note.
  assign start_idx = ({1'b0, cmd_ch.start_note} >= song_len) ? '0 : cmd_ch.start_note;
  assign is_last   = {1'b0, note_pointer} >= (song_len - mns_pkg::SONG_W'(1));

  // Both countdowns stop at zero.
  assign session_dec = (session_remaining != '0) ?
                       session_remaining - mns_pkg::SESS_W'(1) : '0;
  assign note_dec    = (note_remaining != '0) ? note_remaining - mns_pkg::LEN_W'(1) : '0;

  assign tempo_eff = (tempo_bpm == '0) ? mns_pkg::TEMPO_W'(1) : tempo_bpm;
  assign code_mag  = note_code[mns_pkg::CODE_W-1] ? (~note_code + mns_pkg::CODE_W'(1))
                                                  : note_code;

  // Dotted notes get half again, then the length saturates at the field range.
  always_comb begin
    if (note_code[mns_pkg::CODE_W-1]) begin
      len_sum = {1'b0, div_rsp.quotient} + {2'b00, div_rsp.quotient[mns_pkg::DVD_W-1:1]};
    end else begin
      len_sum = {1'b0, div_rsp.quotient};
    end
    if (len_sum > (mns_pkg::DVD_W + 1)'(mns_pkg::LEN_MAX)) begin
      len_sat = mns_pkg::LEN_W'(mns_pkg::LEN_MAX);
    end else begin
      len_sat = len_sum[mns_pkg::LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_READY;
      tempo_bpm         <= mns_pkg::TEMPO_RESET;
      song_notes        <= mns_pkg::SONG_RESET;
      note_pointer      <= '0;
      note_remaining    <= '0;
      session_remaining <= '0;
      playing           <= 1'b0;
      out_valid         <= 1'b0;
      div_req.start     <= 1'b0;
    end else begin
      div_req.start <= 1'b0;

      if (cfg_wr_en) begin
        unique case (cfg_index)
          mns_pkg::REG_TEMPO: tempo_bpm  <= cfg_data[mns_pkg::TEMPO_W-1:0];
          mns_pkg::REG_SONG:  song_notes <= cfg_data[mns_pkg::SONG_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && evt_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_READY: begin
          if (accept) begin
            unique case (cmd_ch.cmd)
              mns_pkg::CMD_START: begin
                note_pointer      <= start_idx;
                session_remaining <= cmd_ch.session_ms;
                note_remaining    <= '0;
                if (cmd_ch.session_ms == '0) begin
                  // An empty budget stops at once and leaves the block idle.
                  playing   <= 1'b0;
                  res_kind  <= mns_pkg::EVT_STOP;
                  res_pitch <= '0;
                  res_len   <= '0;
                  res_next  <= start_idx;
                  state     <= S_EMIT;
                end else begin
                  state <= S_FETCH;
                end
              end
              mns_pkg::CMD_TICK: begin
                if (playing) begin
                  session_remaining <= session_dec;
                  note_remaining    <= note_dec;
                  if (note_dec == '0) begin
                    if (is_last) begin
                      // Finishing the song wins over an expired session.
                      playing      <= 1'b0;
                      note_pointer <= '0;
                      res_kind     <= mns_pkg::EVT_DONE;
                      res_pitch    <= '0;
                      res_len      <= '0;
                      res_next     <= '0;
                      state        <= S_EMIT;
                    end else begin
                      note_pointer <= note_pointer + mns_pkg::NOTE_AW'(1);
                      if (session_dec == '0) begin
                        playing   <= 1'b0;
                        res_kind  <= mns_pkg::EVT_STOP;
                        res_pitch <= '0;
                        res_len   <= '0;
                        res_next  <= note_pointer + mns_pkg::NOTE_AW'(1);
                        state     <= S_EMIT;
                      end else begin
                        state <= S_FETCH;
                      end
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end

        S_FETCH: begin
          // The table read is issued this cycle; data arrives in S_LOAD.
          state <= S_LOAD;
        end

        S_LOAD: begin
          note_pitch       <= ram_rd_data[mns_pkg::ENTRY_W-1:mns_pkg::CODE_W];
          note_code        <= ram_rd_data[mns_pkg::CODE_W-1:0];
          div_req.start    <= 1'b1;
          div_req.dividend <= mns_pkg::DVD_W'(mns_pkg::WHOLE_NOTE_MS);
          div_req.divisor  <= mns_pkg::DVS_W'(tempo_eff);
          state            <= S_WHOLE;
        end

        S_WHOLE: begin
          if (div_rsp.done) begin
            if (note_code == '0) begin
              // A zero code gives a note of no length, over on the next tick.
              note_remaining <= '0;
              playing        <= 1'b1;
              res_kind       <= mns_pkg::EVT_NOTE;
              res_pitch      <= note_pitch;
              res_len        <= '0;
              res_next       <= note_pointer;
              state          <= S_EMIT;
            end else begin
              div_req.start    <= 1'b1;
              div_req.dividend <= div_rsp.quotient;
              div_req.divisor  <= {{(mns_pkg::DVS_W - mns_pkg::CODE_W){1'b0}}, code_mag};
              state            <= S_DIVIDE;
            end
          end
        end

        S_DIVIDE: begin
          if (div_rsp.done) begin
            note_remaining <= len_sat;
            playing        <= 1'b1;
            res_kind       <= mns_pkg::EVT_NOTE;
            res_pitch      <= note_pitch;
            res_len        <= len_sat;
            res_next       <= note_pointer;
            state          <= S_EMIT;
          end
        end

        S_EMIT: begin
          // Hand the event to the output register once it has room.
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= res_kind;
            out_pitch <= res_pitch;
            out_len   <= res_len;
            out_next  <= res_next;
            state     <= S_READY;
          end
        end

        default: state <= S_READY;
      endcase
    end
  end

  assign cmd_ch.ready      = (state == S_READY);
  assign evt_ch.valid      = out_valid;
  assign evt_ch.event_kind = out_kind;
  assign evt_ch.pitch_hz   = out_pitch;
  assign evt_ch.length_ms  = out_len;
  assign evt_ch.next_note  = out_next;

endmodule
